[design/fbm_value_noise_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the fractal value noise block
// Shared property templates clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef FBM_VALUE_NOISE_MACROS_SVH
`define FBM_VALUE_NOISE_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define FBMVN_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define FBMVN_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[design/fbmvn_pkg.sv]
// ----------------------------------------------------------------------------
// Fractal value noise package
// Fixed-point constants and the lattice hash and blend functions.
// ----------------------------------------------------------------------------
`default_nettype none

package fbmvn_pkg;

	localparam int COORD_W = 20;
	localparam int NOISE_W = 16;
	localparam int QBITS   = 24;

	localparam logic [23:0] K013    = 24'd2181038;
	localparam logic [26:0] K3333   = 27'd55918461;
	localparam logic [24:0] QONE    = 25'h1000000;
	localparam logic [25:0] THREE_Q = 26'd50331648;

	// Hash of one lattice point from its scaled components and their squares.
	function automatic logic [23:0] lattice_hash(input logic [23:0] qx, input logic [23:0] qy,
			input logic [50:0] px, input logic [50:0] py);
		logic [51:0] sum;
		logic [27:0] dot;
		sum = {1'b0, px} + {1'b0, py};
		dot = sum[51:24];
		return qx + qy + {dot[22:0], 1'b0};
	endfunction

	// Linear blend of two Q.24 values by a Q.24 weight.
	function automatic logic [23:0] blend(input logic [23:0] lo, input logic [23:0] hi,
			input logic [24:0] w);
		logic [49:0] sum;
		sum = ({26'd0, lo} * {25'd0, QONE - w}) + ({26'd0, hi} * {25'd0, w});
		return sum[47:24];
	endfunction

endpackage

`default_nettype wire

[design/fbmvn_cell.sv]
// ----------------------------------------------------------------------------
// Octave cell
// Evaluates one octave of value noise in five stages and adds it to the
// running sum handed on by the previous cell.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fbm_value_noise_macros.svh"

module fbmvn_cell import fbmvn_pkg::*; #(
	parameter int OCTAVE              = 0,
	parameter int OCTAVE_COUNT        = 6,
	parameter int COORD_FRACTION_BITS = 8,
	parameter int ACC_W               = 30
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               in_valid,
	input  wire logic [COORD_W-1:0] in_x,
	input  wire logic [COORD_W-1:0] in_y,
	input  wire logic [ACC_W-1:0]   in_acc,
	output logic                    out_valid,
	output logic [COORD_W-1:0]      out_x,
	output logic [COORD_W-1:0]      out_y,
	output logic [ACC_W-1:0]        out_acc
);

	localparam int SW    = COORD_W + OCTAVE_COUNT;
	localparam int SHIFT = OCTAVE_COUNT - 1 - OCTAVE;
	localparam logic [SW-1:0] FMASK = SW'((1 << COORD_FRACTION_BITS) - 1);

	logic [SW-1:0] sx, sy, ix, iy;
	logic [23:0]   fx, fy, ix0, ix1, iy0, iy1;
	logic [47:0]   mqx0, mqx1, mqy0, mqy1, mfx, mfy;
	logic [26:0]   ax0, ax1, ay0, ay1;
	logic [49:0]   mux, muy;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [COORD_W-1:0] x_s1, x_s2, x_s3, x_s4, x_s5;
	logic [COORD_W-1:0] y_s1, y_s2, y_s3, y_s4, y_s5;
	logic [ACC_W-1:0]   acc_s1, acc_s2, acc_s3, acc_s4, acc_s5;
	logic [23:0] qx0_s1, qx1_s1, qy0_s1, qy1_s1, f2x_s1, f2y_s1;
	logic [25:0] tx_s1, ty_s1;
	logic [23:0] qx0_s2, qx1_s2, qy0_s2, qy1_s2;
	logic [50:0] px0_s2, px1_s2, py0_s2, py1_s2;
	logic [24:0] ux_s2, uy_s2, ux_s3, uy_s3, uy_s4;
	logic [23:0] a_s3, b_s3, c_s3, d_s3, top_s4, bot_s4;

	always_comb begin
		sx   = SW'(in_x) << OCTAVE;
		sy   = SW'(in_y) << OCTAVE;
		ix   = sx >> COORD_FRACTION_BITS;
		iy   = sy >> COORD_FRACTION_BITS;
		fx   = 24'(sx & FMASK) << (QBITS - COORD_FRACTION_BITS);
		fy   = 24'(sy & FMASK) << (QBITS - COORD_FRACTION_BITS);
		ix0  = 24'(ix);
		ix1  = 24'(ix) + 24'd1;
		iy0  = 24'(iy);
		iy1  = 24'(iy) + 24'd1;
		mqx0 = {24'd0, ix0} * {24'd0, K013};
		mqx1 = {24'd0, ix1} * {24'd0, K013};
		mqy0 = {24'd0, iy0} * {24'd0, K013};
		mqy1 = {24'd0, iy1} * {24'd0, K013};
		mfx  = {24'd0, fx} * {24'd0, fx};
		mfy  = {24'd0, fy} * {24'd0, fy};
		ax0  = {3'd0, qx0_s1} + K3333;
		ax1  = {3'd0, qx1_s1} + K3333;
		ay0  = {3'd0, qy0_s1} + K3333;
		ay1  = {3'd0, qy1_s1} + K3333;
		mux  = {26'd0, f2x_s1} * {24'd0, tx_s1};
		muy  = {26'd0, f2y_s1} * {24'd0, ty_s1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1   <= in_x;
			y_s1   <= in_y;
			acc_s1 <= in_acc;
			qx0_s1 <= mqx0[23:0];
			qx1_s1 <= mqx1[23:0];
			qy0_s1 <= mqy0[23:0];
			qy1_s1 <= mqy1[23:0];
			f2x_s1 <= mfx[47:24];
			f2y_s1 <= mfy[47:24];
			tx_s1  <= THREE_Q - {1'b0, fx, 1'b0};
			ty_s1  <= THREE_Q - {1'b0, fy, 1'b0};

			x_s2   <= x_s1;
			y_s2   <= y_s1;
			acc_s2 <= acc_s1;
			qx0_s2 <= qx0_s1;
			qx1_s2 <= qx1_s1;
			qy0_s2 <= qy0_s1;
			qy1_s2 <= qy1_s1;
			px0_s2 <= {27'd0, qx0_s1} * {24'd0, ax0};
			px1_s2 <= {27'd0, qx1_s1} * {24'd0, ax1};
			py0_s2 <= {27'd0, qy0_s1} * {24'd0, ay0};
			py1_s2 <= {27'd0, qy1_s1} * {24'd0, ay1};
			ux_s2  <= mux[48:24];
			uy_s2  <= muy[48:24];

			x_s3   <= x_s2;
			y_s3   <= y_s2;
			acc_s3 <= acc_s2;
			a_s3   <= lattice_hash(qx0_s2, qy0_s2, px0_s2, py0_s2);
			b_s3   <= lattice_hash(qx1_s2, qy0_s2, px1_s2, py0_s2);
			c_s3   <= lattice_hash(qx0_s2, qy1_s2, px0_s2, py1_s2);
			d_s3   <= lattice_hash(qx1_s2, qy1_s2, px1_s2, py1_s2);
			ux_s3  <= ux_s2;
			uy_s3  <= uy_s2;

			x_s4   <= x_s3;
			y_s4   <= y_s3;
			acc_s4 <= acc_s3;
			top_s4 <= blend(a_s3, b_s3, ux_s3);
			bot_s4 <= blend(c_s3, d_s3, ux_s3);
			uy_s4  <= uy_s3;

			x_s5   <= x_s4;
			y_s5   <= y_s4;
			acc_s5 <= acc_s4 + (ACC_W'(blend(top_s4, bot_s4, uy_s4)) << SHIFT);
		end
	end

	assign out_valid = v_s5;
	assign out_x     = x_s5;
	assign out_y     = y_s5;
	assign out_acc   = acc_s5;

	`FBMVN_ASSERT_NEXT(a_enter, en && in_valid, v_s1)
	`FBMVN_ASSERT_NEXT(a_hold, !en, $stable({v_s1, v_s2, v_s3, v_s4, v_s5}))
	`FBMVN_ASSERT_NOW(a_weight_x, v_s2, ux_s2[24] == 1'b0)
	`FBMVN_ASSERT_NOW(a_weight_y, v_s2, uy_s2[24] == 1'b0)

endmodule

`default_nettype wire

[design/fbm_value_noise.sv]
// Throughput: one item per cycle unless a result waits; five stages per cell.
// The whole chain advances together and holds while a result waits.
// Reset clears only the valid bits of the pipeline.
// ----------------------------------------------------------------------------
// Fractal value noise top level
// A chain of octave cells sums value noise over OCTAVE_COUNT octaves.
// ----------------------------------------------------------------------------
`default_nettype none

module fbm_value_noise import fbmvn_pkg::*; #(
	parameter int OCTAVE_COUNT        = 6,
	parameter int COORD_FRACTION_BITS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [39:0] s_axis_tdata,  // coord_x [19:0], coord_y [39:20]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata   // noise_value [15:0]
);

	localparam int ACC_W = QBITS + OCTAVE_COUNT;

	logic                en;
	logic                cv   [OCTAVE_COUNT+1];
	logic [COORD_W-1:0]  cx   [OCTAVE_COUNT+1];
	logic [COORD_W-1:0]  cy   [OCTAVE_COUNT+1];
	logic [ACC_W-1:0]    cacc [OCTAVE_COUNT+1];

	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;
	assign cv[0]         = s_axis_tvalid;
	assign cx[0]         = s_axis_tdata[COORD_W-1:0];
	assign cy[0]         = s_axis_tdata[2*COORD_W-1:COORD_W];
	assign cacc[0]       = '0;

	for (genvar k = 0; k < OCTAVE_COUNT; k++) begin : g_cell
		fbmvn_cell #(
			.OCTAVE              (k),
			.OCTAVE_COUNT        (OCTAVE_COUNT),
			.COORD_FRACTION_BITS (COORD_FRACTION_BITS),
			.ACC_W               (ACC_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (cv[k]),
			.in_x      (cx[k]),
			.in_y      (cy[k]),
			.in_acc    (cacc[k]),
			.out_valid (cv[k+1]),
			.out_x     (cx[k+1]),
			.out_y     (cy[k+1]),
			.out_acc   (cacc[k+1])
		);
	end

	assign m_axis_tvalid = cv[OCTAVE_COUNT];
	assign m_axis_tdata  = NOISE_W'(cacc[OCTAVE_COUNT] >> (OCTAVE_COUNT + 8));

endmodule

`default_nettype wire

[dv/fbm_noise_checker.sv]
// ----------------------------------------------------------------------------
// Fractal value noise checker
// Watches both streams, computes the expected noise for each accepted
// coordinate and compares it with the results in arrival order.
// ----------------------------------------------------------------------------
`default_nettype none

module fbm_noise_checker #(
	parameter int OCTAVE_COUNT        = 6,
	parameter int COORD_FRACTION_BITS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	input  wire logic        s_axis_tready,
	input  wire logic [39:0] s_axis_tdata,
	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic [15:0] m_axis_tdata,
	output int               error_count,
	output int               pending_count,
	output int               result_count
);

	localparam logic [63:0] UNIT   = 64'd1 << 24;
	localparam logic [63:0] Q_MASK = UNIT - 1;
	localparam logic [63:0] MUL013 = 64'd2181038;
	localparam logic [63:0] ADD3333 = 64'd55918461;

	logic [15:0] noise_expected[$];

	function automatic logic [63:0] point_hash(input logic [63:0] px, input logic [63:0] py);
		logic [63:0] qx, qy, dot;
		qx = (px * MUL013) & Q_MASK;
		qy = (py * MUL013) & Q_MASK;
		dot = (qx * (qx + ADD3333) + qy * (qy + ADD3333)) >> 24;
		return (qx + qy + 2 * dot) & Q_MASK;
	endfunction

	function automatic logic [63:0] smooth(input logic [63:0] f);
		logic [63:0] f2;
		f2 = (f * f) >> 24;
		return (f2 * (3 * UNIT - 2 * f)) >> 24;
	endfunction

	function automatic logic [63:0] mix(input logic [63:0] lo, input logic [63:0] hi,
			input logic [63:0] w);
		return (lo * (UNIT - w) + hi * w) >> 24;
	endfunction

	function automatic logic [15:0] fractal_noise(input logic [19:0] cx,
			input logic [19:0] cy);
		logic [63:0] sx, sy, ix, iy, fx, fy, ux, uy, top, bot, acc;
		acc = 0;
		for (int k = 0; k < OCTAVE_COUNT; k++) begin
			sx = 64'(cx) << k;
			sy = 64'(cy) << k;
			ix = sx >> COORD_FRACTION_BITS;
			iy = sy >> COORD_FRACTION_BITS;
			fx = (sx & ((64'd1 << COORD_FRACTION_BITS) - 1)) << (24 - COORD_FRACTION_BITS);
			fy = (sy & ((64'd1 << COORD_FRACTION_BITS) - 1)) << (24 - COORD_FRACTION_BITS);
			ux = smooth(fx);
			uy = smooth(fy);
			top = mix(point_hash(ix, iy), point_hash(ix + 1, iy), ux);
			bot = mix(point_hash(ix, iy + 1), point_hash(ix + 1, iy + 1), ux);
			acc += mix(top, bot, uy) << (OCTAVE_COUNT - 1 - k);
		end
		return 16'(acc >> (OCTAVE_COUNT + 8));
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_count   <= 0;
			result_count  <= 0;
			pending_count <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				result_count <= result_count + 1;
				if (noise_expected.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h", $time,
						m_axis_tdata);
					error_count <= error_count + 1;
				end else begin
					if (m_axis_tdata !== noise_expected[0]) begin
						$display("%0t: noise_value mismatch, expected %h, actual %h", $time,
							noise_expected[0], m_axis_tdata);
						error_count <= error_count + 1;
					end
					void'(noise_expected.pop_front());
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				noise_expected.insert(noise_expected.size(),
					fractal_noise(s_axis_tdata[19:0], s_axis_tdata[39:20]));
			pending_count <= noise_expected.size();
		end
	end

endmodule

`default_nettype wire

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// Fractal value noise testbench
// Drives directed and random coordinates under several idle and stall
// patterns, including a long output hold-off, and reports the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	int          error_count, pending_count, result_count;
	int          send_idle_pct = 0;
	int          stall_pct = 0;
	bit          hold_off = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	fbm_value_noise dut (.*);
	fbm_noise_checker checker_i (.*);

	always @(posedge clk) begin
		if (hold_off)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	task automatic send_coord(input logic [19:0] cx, input logic [19:0] cy);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {cy, cx};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	function automatic logic [19:0] rand_coord();
		case ($urandom_range(3))
			0: return 20'($urandom);
			1: return 20'($urandom_range(4095));
			2: return {12'hFFF, 8'($urandom)};
			default: return {12'($urandom), 8'h00};
		endcase
	endfunction

	initial begin
		#400000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_coord(20'h00000, 20'h00000);
		send_coord(20'hFFFFF, 20'hFFFFF);
		send_coord(20'hFFFFF, 20'h00000);
		send_coord(20'h00000, 20'hFFFFF);
		send_coord(20'hFFF00, 20'hFFF00);
		send_coord(20'h00100, 20'h00200);
		send_coord(20'h000FF, 20'h00080);
		send_coord(20'h00001, 20'h00001);
		send_coord(20'hAAAAA, 20'h55555);
		send_coord(20'h55555, 20'hAAAAA);
		send_coord(20'h7FFFF, 20'h80000);
		send_coord(20'h80000, 20'h7FFFF);
		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct = (phase == 1 || phase == 3) ? 86 : (phase == 3 ? 20 : 0);
			stall_pct     = (phase == 2) ? 86 : 0;
			if (phase == 3) begin
				send_idle_pct = 20;
				stall_pct = 20;
			end
			if (phase == 0) begin
				fork
					begin
						hold_off = 1'b1;
						repeat (200) @(posedge clk);
						hold_off = 1'b0;
					end
				join_none
			end
			repeat (385) send_coord(rand_coord(), rand_coord());
		end
		s_axis_tvalid <= 1'b0;
		while (pending_count != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		$display("Covered %0d results: field extremes, lattice edges, zero fractions,", result_count);
		$display("random coordinates under idle, stall and long output hold-off patterns.");
		if (error_count == 0 && pending_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire
